### rtl/core/leb_pkg.sv
// Package with the item types, command codes and cell controls of the line edit buffer.
`default_nettype none
package leb_pkg;

  localparam int CP_W  = 21;
  localparam int POS_W = 9;

  localparam logic [CP_W-1:0] CP_BACKSPACE = 21'd8;
  localparam logic [CP_W-1:0] CP_TAB       = 21'd9;
  localparam logic [CP_W-1:0] CP_LINEFEED  = 21'd10;
  localparam logic [CP_W-1:0] CP_RETURN    = 21'd13;

  typedef enum logic [3:0] {
    MODE_INSERT     = 4'd0,
    MODE_DEL_BEFORE = 4'd1,
    MODE_DEL_AFTER  = 4'd2,
    MODE_LEFT       = 4'd3,
    MODE_RIGHT      = 4'd4,
    MODE_HOME       = 4'd5,
    MODE_END        = 4'd6,
    MODE_SET        = 4'd7,
    MODE_CLEAR      = 4'd8,
    MODE_READ       = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctl_state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CP_W-1:0]   cp;
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [CP_W-1:0]   code_point;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_now;
    logic [POS_W-1:0]  text_length;
    logic              changed;
    logic              full_res;
    logic [CP_W-1:0]   read_value;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/line_edit_buffer_top.sv
// Top level of the line edit buffer: sequencer plus a ring of character cells.
//
//  Channel   Ports                     Handshake
//  command   start, busy, in_item      taken when start is high and busy is low
//  result    out_valid, out_item       one-cycle strobe, always taken
//
// Edit and cursor commands leave busy low, and the result appears in the
// next cycle while a new command may already be taken.
// A read rotates the cell ring once around with busy high, and the result
// appears in the cycle after the last rotation.
// The result side never stalls; a new command waits only while a read sweep runs.
// Reset clears cursor, length and the strobe; cell contents are not reset.
`default_nettype none
module line_edit_buffer_top #(
  parameter int MAX_CHARS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire leb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output leb_pkg::out_item_t      out_item
);

  localparam int LEN_W = $clog2(MAX_CHARS + 1);
  localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  leb_pkg::cell_ctrl_t      cell_ctrl;
  logic [IDX_W-1:0]         cell_idx;
  logic [leb_pkg::CP_W-1:0] cell_q [MAX_CHARS];

  leb_ctrl #(
    .MAX_CHARS (MAX_CHARS),
    .LEN_W     (LEN_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .head_q    (cell_q[0]),
    .busy      (busy),
    .cell_ctrl (cell_ctrl),
    .cell_idx  (cell_idx),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
    leb_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .idx     (cell_idx),
      .left_q  (cell_q[(i + MAX_CHARS - 1) % MAX_CHARS]),
      .right_q (cell_q[(i + 1) % MAX_CHARS]),
      .q       (cell_q[i])
    );
  end

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid) else $error("result strobe during a read sweep");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.cursor_now <= out_item.text_length))
    else $error("cursor beyond text length");

  a_full_not_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.full_res) |-> !out_item.changed)
    else $error("dropped insert reported as a change");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.mode == leb_pkg::MODE_READ)) |=> busy)
    else $error("read command did not start a sweep");

endmodule
`default_nettype wire

### rtl/core/leb_cell.sv
// One storage cell of the character chain, shifting with its neighbors.
`default_nettype none
module leb_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 8
) (
  input  wire logic                    clk,
  input  wire leb_pkg::cell_ctrl_t     ctrl,
  input  wire logic [IDX_W-1:0]        idx,
  input  wire logic [leb_pkg::CP_W-1:0] left_q,
  input  wire logic [leb_pkg::CP_W-1:0] right_q,
  output logic [leb_pkg::CP_W-1:0]     q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [leb_pkg::CP_W-1:0] q_r;
  logic [leb_pkg::CP_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.op)
      leb_pkg::CELL_INSERT: begin
        if (MY_IDX == idx) begin
          q_nxt = ctrl.cp;
        end else if (MY_IDX > idx) begin
          q_nxt = left_q;
        end
      end
      leb_pkg::CELL_DELETE: begin
        if (MY_IDX >= idx) begin
          q_nxt = right_q;
        end
      end
      leb_pkg::CELL_ROTATE: q_nxt = right_q;
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

### rtl/core/leb_ctrl.sv
// Command sequencer holding cursor and length and steering the cell chain.
`default_nettype none
module leb_ctrl #(
  parameter int MAX_CHARS = 256,
  parameter int LEN_W     = 9,
  parameter int IDX_W     = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire leb_pkg::in_item_t        in_item,
  input  wire logic [leb_pkg::CP_W-1:0] head_q,
  output logic                          busy,
  output leb_pkg::cell_ctrl_t           cell_ctrl,
  output logic [IDX_W-1:0]              cell_idx,
  output logic                          out_valid,
  output leb_pkg::out_item_t            out_item
);

  localparam int CMP_W = (LEN_W > leb_pkg::POS_W) ? LEN_W : leb_pkg::POS_W;
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_CHARS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHARS - 1);

  leb_pkg::ctl_state_t state_r, state_nxt;
  logic [LEN_W-1:0]    cur_r, cur_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [CMP_W-1:0]    pos_r, pos_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [leb_pkg::CP_W-1:0] rd_r, rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  leb_pkg::out_item_t  out_r, out_nxt;

  logic                accept;
  logic                changed;
  logic                full;
  logic                skip_cp;
  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    len_x;
  logic                hit;

  assign accept  = start && (state_r == leb_pkg::ST_IDLE);
  assign pos_x   = CMP_W'(in_item.position);
  assign len_x   = CMP_W'(len_r);
  assign skip_cp = (in_item.code_point == leb_pkg::CP_BACKSPACE) ||
                   (in_item.code_point == leb_pkg::CP_TAB) ||
                   (in_item.code_point == leb_pkg::CP_LINEFEED) ||
                   (in_item.code_point == leb_pkg::CP_RETURN);
  assign hit     = rd_ok_r && (CMP_W'(cnt_r) == pos_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      leb_pkg::ST_IDLE: begin
        if (accept && (leb_pkg::mode_t'(in_item.mode) == leb_pkg::MODE_READ)) begin
          state_nxt = leb_pkg::ST_READ;
        end
      end
      leb_pkg::ST_READ: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = leb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = leb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    rd_ok_nxt     = rd_ok_r;
    rd_nxt        = rd_r;
    changed       = 1'b0;
    full          = 1'b0;
    cell_ctrl.op  = leb_pkg::CELL_HOLD;
    cell_ctrl.cp  = in_item.code_point;
    cell_idx      = IDX_W'(cur_r);
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      leb_pkg::ST_IDLE: begin
        if (accept) begin
          case (leb_pkg::mode_t'(in_item.mode))
            leb_pkg::MODE_INSERT: begin
              if (!skip_cp) begin
                if (len_r == MAX_LEN) begin
                  full = 1'b1;
                end else begin
                  cell_ctrl.op = leb_pkg::CELL_INSERT;
                  cur_nxt = cur_r + 1'b1;
                  len_nxt = len_r + 1'b1;
                  changed = 1'b1;
                end
              end
            end
            leb_pkg::MODE_DEL_BEFORE: begin
              if (cur_r != '0) begin
                cell_ctrl.op = leb_pkg::CELL_DELETE;
                cell_idx = IDX_W'(cur_r - 1'b1);
                cur_nxt = cur_r - 1'b1;
                len_nxt = len_r - 1'b1;
                changed = 1'b1;
              end
            end
            leb_pkg::MODE_DEL_AFTER: begin
              if (cur_r < len_r) begin
                cell_ctrl.op = leb_pkg::CELL_DELETE;
                len_nxt = len_r - 1'b1;
                changed = 1'b1;
              end
            end
            leb_pkg::MODE_LEFT: begin
              if (cur_r != '0) begin
                cur_nxt = cur_r - 1'b1;
              end
            end
            leb_pkg::MODE_RIGHT: begin
              if (cur_r < len_r) begin
                cur_nxt = cur_r + 1'b1;
              end
            end
            leb_pkg::MODE_HOME: cur_nxt = '0;
            leb_pkg::MODE_END:  cur_nxt = len_r;
            leb_pkg::MODE_SET:  cur_nxt = (pos_x > len_x) ? len_r : LEN_W'(pos_x);
            leb_pkg::MODE_CLEAR: begin
              changed = (len_r != '0);
              cur_nxt = '0;
              len_nxt = '0;
            end
            leb_pkg::MODE_READ: begin
              cnt_nxt   = '0;
              pos_nxt   = pos_x;
              rd_ok_nxt = (pos_x < len_x);
              rd_nxt    = '0;
            end
            default: ;
          endcase
          if (leb_pkg::mode_t'(in_item.mode) != leb_pkg::MODE_READ) begin
            out_valid_nxt       = 1'b1;
            out_nxt.cursor_now  = leb_pkg::POS_W'(cur_nxt);
            out_nxt.text_length = leb_pkg::POS_W'(len_nxt);
            out_nxt.changed     = changed;
            out_nxt.full_res    = full;
            out_nxt.read_value  = '0;
          end
        end
      end
      leb_pkg::ST_READ: begin
        cell_ctrl.op = leb_pkg::CELL_ROTATE;
        cnt_nxt = cnt_r + 1'b1;
        if (hit) begin
          rd_nxt = head_q;
        end
        if (cnt_r == LAST_IDX) begin
          out_valid_nxt       = 1'b1;
          out_nxt.cursor_now  = leb_pkg::POS_W'(cur_r);
          out_nxt.text_length = leb_pkg::POS_W'(len_r);
          out_nxt.changed     = 1'b0;
          out_nxt.full_res    = 1'b0;
          out_nxt.read_value  = hit ? head_q : rd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= leb_pkg::ST_IDLE;
      cur_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    pos_r   <= pos_nxt;
    rd_ok_r <= rd_ok_nxt;
    rd_r    <= rd_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != leb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire
